// ----- design/qdsm_pkg.sv -----
// Package for the quadrature decoder with speed meter.
// Holds payload structs, register indexes, sequencer states, the transition table
// and the saturation and magnitude helpers. No dependencies.
package qdsm_pkg;

   localparam int COUNT_W   = 32;
   localparam int Q_W       = 32;
   localparam int Q_FRAC    = 16;
   localparam int ALPHA_W   = 17;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W     = 32;
   localparam int MUL_W     = COUNT_W + 1;
   localparam int PROD_W    = COUNT_W + Q_W;
   localparam int ACC_W     = Q_W + Q_FRAC + 2;
   localparam int DIV_CNT_W = $clog2(Q_W);

   localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);
   localparam logic [ACC_W-1:0]   FLT_ROUND = ACC_W'(32768);

   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_GAIN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_GAIN  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_ALPHA = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_ALPHA = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_TICKS   = 3'd4;

   localparam logic [1:0] MODE_PIN   = 2'd0;
   localparam logic [1:0] MODE_POS   = 2'd1;
   localparam logic [1:0] MODE_SPEED = 2'd2;

   localparam logic [Q_W-1:0]     RST_ANGLE_GAIN  = 32'd65536;
   localparam logic [Q_W-1:0]     RST_SPEED_GAIN  = 32'd65536;
   localparam logic [ALPHA_W-1:0] RST_ANGLE_ALPHA = 17'd6554;
   localparam logic [ALPHA_W-1:0] RST_SPEED_ALPHA = 17'd6554;
   localparam logic [Q_W-1:0]     RST_MIN_TICKS   = 32'd100;

   // index = {new A/B state, previous A/B state}
   localparam logic signed [1:0] STEP_LUT [16] = '{
      2'sb00, 2'sb01, 2'sb11, 2'sb00,
      2'sb11, 2'sb00, 2'sb00, 2'sb01,
      2'sb01, 2'sb00, 2'sb00, 2'sb11,
      2'sb00, 2'sb11, 2'sb01, 2'sb00
   };

   typedef struct packed {
      logic [1:0]  mode;
      logic        pin_a;
      logic        pin_b;
      logic [31:0] elapsed_ticks;
   } req_type;

   typedef struct packed {
      logic signed [1:0]  step;
      logic signed [31:0] position_count;
      logic               direction;
      logic signed [31:0] angle_filtered;
      logic signed [31:0] speed_raw;
      logic signed [31:0] speed_filtered;
      logic               speed_updated;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ANG_MUL,
      ST_ANG_SAT,
      ST_SPD_MUL,
      ST_SPD_CHK,
      ST_SPD_DIV,
      ST_SPD_SAT,
      ST_FLT_A,
      ST_FLT_B,
      ST_FLT_C,
      ST_RESP
   } state_type;

   function automatic logic [COUNT_W-1:0] cnt_abs(input logic [COUNT_W-1:0] v);
      return v[COUNT_W-1] ? (~v + COUNT_W'(1)) : v;
   endfunction

   // signed saturation of a sign and magnitude pair to Q_W bits
   function automatic logic [Q_W-1:0] sat_q(input logic neg, input logic [PROD_W-1:0] mag);
      logic [PROD_W-1:0] lim;
      lim = PROD_W'(1) << (Q_W - 1);
      if (!neg) begin
         return (mag >= lim) ? {1'b0, {(Q_W-1){1'b1}}} : mag[Q_W-1:0];
      end
      return (mag >= lim) ? {1'b1, {(Q_W-1){1'b0}}} : (~mag[Q_W-1:0] + Q_W'(1));
   endfunction

endpackage

// ----- design/quadrature_decoder_speed_meter.sv -----
// Quadrature decoder with angle and M-method speed measurement, one channel.
// Pin samples, skipped speed updates and unused modes go straight to the result register;
// a position update multiplies and saturates, then may filter; a speed update multiplies,
// checks for overflow, runs the restoring divider unless the quotient overflows, saturates
// and may filter. One item at a time: the input stalls until the result is loaded.
// Sync active-high reset clears counts, filters, pin state, loads defaults; needs qdsm_pkg.
module quadrature_decoder_speed_meter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  qdsm_pkg::req_type                   req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output qdsm_pkg::rsp_type                   rsp_payload,
   input  logic                                csr_write,
   input  logic [qdsm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [qdsm_pkg::CSR_W-1:0]          csr_wdata
);

   localparam int CW = qdsm_pkg::COUNT_W;
   localparam int QW = qdsm_pkg::Q_W;
   localparam int AW = qdsm_pkg::ALPHA_W;
   localparam int MW = qdsm_pkg::MUL_W;
   localparam int PW = qdsm_pkg::PROD_W;
   localparam int XW = qdsm_pkg::ACC_W;
   localparam int NW = qdsm_pkg::DIV_CNT_W;
   localparam int FR = qdsm_pkg::Q_FRAC;

   qdsm_pkg::state_type state_ff, state_in;

   logic [QW-1:0] angle_gain_ff, angle_gain_in;
   logic [QW-1:0] speed_gain_ff, speed_gain_in;
   logic [AW-1:0] angle_alpha_ff, angle_alpha_in;
   logic [AW-1:0] speed_alpha_ff, speed_alpha_in;
   logic [QW-1:0] min_ticks_ff, min_ticks_in;

   logic [1:0]           pin_state_ff, pin_state_in;
   logic [CW-1:0]        running_ff, running_in;
   logic [CW-1:0]        snapshot_ff, snapshot_in;
   logic [CW-1:0]        base_ff, base_in;
   logic signed [QW-1:0] flt_angle_ff, flt_angle_in;
   logic signed [QW-1:0] raw_speed_ff, raw_speed_in;
   logic signed [QW-1:0] flt_speed_ff, flt_speed_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   qdsm_pkg::rsp_type    rsp_data_ff, rsp_data_in;

   logic signed [1:0]    step_ff, step_in;
   logic                 updated_ff, updated_in;
   logic                 neg_ff, neg_in;
   logic [CW-1:0]        mag_ff, mag_in;
   logic [QW-1:0]        ticks_ff, ticks_in;
   logic [PW-1:0]        prod_ff, prod_in;
   logic signed [XW-1:0] acc_ff, acc_in;
   logic signed [QW-1:0] sample_ff, sample_in;
   logic                 flt_sel_ff, flt_sel_in;
   logic                 ovf_ff, ovf_in;
   logic [QW-1:0]        rem_ff, rem_in;
   logic [QW-1:0]        quo_ff, quo_in;
   logic [NW-1:0]        cnt_ff, cnt_in;

   logic signed [MW-1:0]   mul_a, mul_b;
   logic signed [2*MW-1:0] mul_p;
   logic [1:0]             pin_cur;
   logic signed [1:0]      lut_step;
   logic [CW-1:0]          delta;
   logic [QW:0]            div_trial;
   logic                   div_ge;
   logic [QW-1:0]          sat_ang;
   logic [QW-1:0]          sat_spd;
   logic [AW-1:0]          alpha_eff;
   logic signed [QW-1:0]   flt_prev;
   logic signed [XW-1:0]   flt_sum;
   logic signed [QW-1:0]   flt_new;
   logic                   accept;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != qdsm_pkg::ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   assign pin_cur   = {req_payload.pin_a, req_payload.pin_b};
   assign lut_step  = qdsm_pkg::STEP_LUT[{pin_cur, pin_state_ff}];
   assign delta     = snapshot_ff - base_ff;
   assign div_trial = {rem_ff, quo_ff[QW-1]};
   assign div_ge    = (div_trial >= {1'b0, ticks_ff});
   assign sat_ang   = qdsm_pkg::sat_q(neg_ff, prod_ff);
   assign sat_spd   = qdsm_pkg::sat_q(neg_ff, ovf_ff ? {PW{1'b1}} : PW'(quo_ff));

   assign alpha_eff = flt_sel_ff
                    ? ((speed_alpha_ff > qdsm_pkg::ALPHA_ONE) ? qdsm_pkg::ALPHA_ONE
                                                               : speed_alpha_ff)
                    : ((angle_alpha_ff > qdsm_pkg::ALPHA_ONE) ? qdsm_pkg::ALPHA_ONE
                                                               : angle_alpha_ff);
   assign flt_prev  = flt_sel_ff ? flt_speed_ff : flt_angle_ff;
   assign flt_sum   = acc_ff + $signed(prod_ff[XW-1:0]) + $signed(qdsm_pkg::FLT_ROUND);
   assign flt_new   = flt_sum[FR+QW-1:FR];

   // shared multiplier, operands chosen by the sequencer
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         qdsm_pkg::ST_ANG_MUL: begin
            mul_a = {{(MW-CW){1'b0}}, mag_ff};
            mul_b = {{(MW-QW){1'b0}}, angle_gain_ff};
         end
         qdsm_pkg::ST_SPD_MUL: begin
            mul_a = {{(MW-CW){1'b0}}, mag_ff};
            mul_b = {{(MW-QW){1'b0}}, speed_gain_ff};
         end
         qdsm_pkg::ST_FLT_A: begin
            mul_a = {{(MW-AW){1'b0}}, alpha_eff};
            mul_b = {{(MW-QW){sample_ff[QW-1]}}, sample_ff};
         end
         qdsm_pkg::ST_FLT_B: begin
            mul_a = {{(MW-AW){1'b0}}, qdsm_pkg::ALPHA_ONE - alpha_eff};
            mul_b = {{(MW-QW){flt_prev[QW-1]}}, flt_prev};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p   = mul_a * mul_b;
   assign prod_in = mul_p[PW-1:0];

   always_comb begin
      state_in       = state_ff;
      angle_gain_in  = angle_gain_ff;
      speed_gain_in  = speed_gain_ff;
      angle_alpha_in = angle_alpha_ff;
      speed_alpha_in = speed_alpha_ff;
      min_ticks_in   = min_ticks_ff;
      pin_state_in   = pin_state_ff;
      running_in     = running_ff;
      snapshot_in    = snapshot_ff;
      base_in        = base_ff;
      flt_angle_in   = flt_angle_ff;
      raw_speed_in   = raw_speed_ff;
      flt_speed_in   = flt_speed_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_data_in    = rsp_data_ff;
      step_in        = step_ff;
      updated_in     = updated_ff;
      neg_in         = neg_ff;
      mag_in         = mag_ff;
      ticks_in       = ticks_ff;
      acc_in         = acc_ff;
      sample_in      = sample_ff;
      flt_sel_in     = flt_sel_ff;
      ovf_in         = ovf_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      cnt_in         = cnt_ff;

      if (csr_write) begin
         unique case (csr_index)
            qdsm_pkg::CSR_ANGLE_GAIN:  angle_gain_in  = csr_wdata[QW-1:0];
            qdsm_pkg::CSR_SPEED_GAIN:  speed_gain_in  = csr_wdata[QW-1:0];
            qdsm_pkg::CSR_ANGLE_ALPHA: angle_alpha_in = csr_wdata[AW-1:0];
            qdsm_pkg::CSR_SPEED_ALPHA: speed_alpha_in = csr_wdata[AW-1:0];
            qdsm_pkg::CSR_MIN_TICKS:   min_ticks_in   = csr_wdata[QW-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         qdsm_pkg::ST_IDLE: begin
            if (accept) begin
               step_in    = 2'sb00;
               updated_in = 1'b0;
               state_in   = qdsm_pkg::ST_RESP;
               unique case (req_payload.mode)
                  qdsm_pkg::MODE_PIN: begin
                     step_in      = lut_step;
                     running_in   = running_ff + {{(CW-2){lut_step[1]}}, lut_step};
                     pin_state_in = pin_cur;
                  end
                  qdsm_pkg::MODE_POS: begin
                     snapshot_in = running_ff;
                     neg_in      = running_ff[CW-1];
                     mag_in      = qdsm_pkg::cnt_abs(running_ff);
                     state_in    = qdsm_pkg::ST_ANG_MUL;
                  end
                  qdsm_pkg::MODE_SPEED: begin
                     if ((req_payload.elapsed_ticks != '0) &&
                         (req_payload.elapsed_ticks >= min_ticks_ff)) begin
                        ticks_in = req_payload.elapsed_ticks;
                        neg_in   = delta[CW-1];
                        mag_in   = qdsm_pkg::cnt_abs(delta);
                        state_in = qdsm_pkg::ST_SPD_MUL;
                     end
                  end
                  default: ;
               endcase
            end
         end
         qdsm_pkg::ST_ANG_MUL: state_in = qdsm_pkg::ST_ANG_SAT;
         qdsm_pkg::ST_ANG_SAT: begin
            sample_in  = sat_ang;
            flt_sel_in = 1'b0;
            if (flt_angle_ff == '0) begin
               flt_angle_in = sat_ang;
               state_in     = qdsm_pkg::ST_RESP;
            end else begin
               state_in = qdsm_pkg::ST_FLT_A;
            end
         end
         qdsm_pkg::ST_SPD_MUL: state_in = qdsm_pkg::ST_SPD_CHK;
         qdsm_pkg::ST_SPD_CHK: begin
            // quotient fits in QW bits only if the high half is below the divisor
            if (prod_ff[PW-1:QW] >= CW'(ticks_ff)) begin
               ovf_in   = 1'b1;
               state_in = qdsm_pkg::ST_SPD_SAT;
            end else begin
               ovf_in   = 1'b0;
               rem_in   = prod_ff[QW+QW-1:QW];
               quo_in   = prod_ff[QW-1:0];
               cnt_in   = '0;
               state_in = qdsm_pkg::ST_SPD_DIV;
            end
         end
         qdsm_pkg::ST_SPD_DIV: begin
            rem_in = div_ge ? QW'(div_trial - {1'b0, ticks_ff}) : div_trial[QW-1:0];
            quo_in = {quo_ff[QW-2:0], div_ge};
            cnt_in = cnt_ff + NW'(1);
            if (cnt_ff == {NW{1'b1}}) begin
               state_in = qdsm_pkg::ST_SPD_SAT;
            end
         end
         qdsm_pkg::ST_SPD_SAT: begin
            raw_speed_in = sat_spd;
            sample_in    = sat_spd;
            base_in      = snapshot_ff;
            updated_in   = 1'b1;
            flt_sel_in   = 1'b1;
            if (flt_speed_ff == '0) begin
               flt_speed_in = sat_spd;
               state_in     = qdsm_pkg::ST_RESP;
            end else begin
               state_in = qdsm_pkg::ST_FLT_A;
            end
         end
         qdsm_pkg::ST_FLT_A: state_in = qdsm_pkg::ST_FLT_B;
         qdsm_pkg::ST_FLT_B: begin
            acc_in   = $signed(prod_ff[XW-1:0]);
            state_in = qdsm_pkg::ST_FLT_C;
         end
         qdsm_pkg::ST_FLT_C: begin
            if (flt_sel_ff) begin
               flt_speed_in = flt_new;
            end else begin
               flt_angle_in = flt_new;
            end
            state_in = qdsm_pkg::ST_RESP;
         end
         qdsm_pkg::ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in.step           = step_ff;
               rsp_data_in.position_count = snapshot_ff[QW-1:0];
               rsp_data_in.direction      = snapshot_ff[CW-1];
               rsp_data_in.angle_filtered = flt_angle_ff;
               rsp_data_in.speed_raw      = raw_speed_ff;
               rsp_data_in.speed_filtered = flt_speed_ff;
               rsp_data_in.speed_updated  = updated_ff;
               rsp_valid_in               = 1'b1;
               state_in                   = qdsm_pkg::ST_IDLE;
            end
         end
         default: state_in = qdsm_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= qdsm_pkg::ST_IDLE;
         angle_gain_ff  <= qdsm_pkg::RST_ANGLE_GAIN;
         speed_gain_ff  <= qdsm_pkg::RST_SPEED_GAIN;
         angle_alpha_ff <= qdsm_pkg::RST_ANGLE_ALPHA;
         speed_alpha_ff <= qdsm_pkg::RST_SPEED_ALPHA;
         min_ticks_ff   <= qdsm_pkg::RST_MIN_TICKS;
         pin_state_ff   <= '0;
         running_ff     <= '0;
         snapshot_ff    <= '0;
         base_ff        <= '0;
         flt_angle_ff   <= '0;
         raw_speed_ff   <= '0;
         flt_speed_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         angle_gain_ff  <= angle_gain_in;
         speed_gain_ff  <= speed_gain_in;
         angle_alpha_ff <= angle_alpha_in;
         speed_alpha_ff <= speed_alpha_in;
         min_ticks_ff   <= min_ticks_in;
         pin_state_ff   <= pin_state_in;
         running_ff     <= running_in;
         snapshot_ff    <= snapshot_in;
         base_ff        <= base_in;
         flt_angle_ff   <= flt_angle_in;
         raw_speed_ff   <= raw_speed_in;
         flt_speed_ff   <= flt_speed_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      step_ff     <= step_in;
      updated_ff  <= updated_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      ticks_ff    <= ticks_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      sample_ff   <= sample_in;
      flt_sel_ff  <= flt_sel_in;
      ovf_ff      <= ovf_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
   end

endmodule

// ----- dv/tb_quadrature_decoder_speed_meter.sv -----
// Self-checking testbench for quadrature_decoder_speed_meter: pin samples, position
// and speed updates checked field by field against an in-bench decoder/meter model.
// Depends on qdsm_pkg and the design top level.
`timescale 1ns / 1ps

module tb_quadrature_decoder_speed_meter;

   localparam int          CLK_HALF     = 6;
   localparam int          LIMIT_CYCLES = 400000;
   localparam logic [1:0]  MODE_UNUSED  = 2'd3;

   // {new A/B state, previous A/B state} -> step
   localparam logic signed [1:0] TRANSITION [16] = '{
      2'sb00, 2'sb01, 2'sb11, 2'sb00,
      2'sb11, 2'sb00, 2'sb00, 2'sb01,
      2'sb01, 2'sb00, 2'sb00, 2'sb11,
      2'sb00, 2'sb11, 2'sb01, 2'sb00
   };

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   qdsm_pkg::req_type              req_payload = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   qdsm_pkg::rsp_type              rsp_payload;
   logic                           csr_write = 1'b0;
   logic [qdsm_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [qdsm_pkg::CSR_W-1:0]     csr_wdata = '0;

   quadrature_decoder_speed_meter u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   // model registers and state
   logic [31:0] cfg_angle_gain  = 32'd65536;
   logic [31:0] cfg_speed_gain  = 32'd65536;
   logic [16:0] cfg_angle_alpha = 17'd6554;
   logic [16:0] cfg_speed_alpha = 17'd6554;
   logic [31:0] cfg_min_ticks   = 32'd100;
   logic [1:0]  st_pins  = '0;
   logic [31:0] st_count = '0;
   logic [31:0] st_snap  = '0;
   logic [31:0] st_base  = '0;
   logic [31:0] st_angle = '0;
   logic [31:0] st_raw   = '0;
   logic [31:0] st_speed = '0;

   qdsm_pkg::rsp_type readout_q [$];
   int      mismatches  = 0;
   int      cycle_count = 0;
   int      snd_idle_pct = 0;
   int      rsp_idle_pct = 0;
   int      hold_left    = 0;

   initial begin
      forever #(CLK_HALF) clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("%0t timeout, %0d transfers outstanding", $time, readout_q.size());
         $display("FAILURE");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
      end
   end

   function automatic logic [63:0] magnitude(input logic [31:0] v);
      logic [31:0] n;
      n = ~v + 32'd1;
      return v[31] ? {32'd0, n} : {32'd0, v};
   endfunction

   function automatic logic [31:0] sat32(input logic neg, input logic [63:0] mag);
      if (!neg) return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
      return (mag >= 64'h8000_0000) ? 32'h8000_0000 : (~mag[31:0] + 32'd1);
   endfunction

   function automatic logic [31:0] lowpass(input logic [31:0] prev, input logic [31:0] x,
                                           input logic [16:0] a);
      longint signed aa;
      longint signed s;
      aa = (a > 17'd65536) ? 65536 : a;
      if (prev == 32'd0) return x;
      s = aa * longint'($signed(x)) + (65536 - aa) * longint'($signed(prev)) + 32768;
      s = s >>> 16;
      return s[31:0];
   endfunction

   function automatic qdsm_pkg::rsp_type meter_step(input qdsm_pkg::req_type r);
      qdsm_pkg::rsp_type o;
      logic signed [1:0] stp;
      logic [1:0]       cur;
      logic [31:0]      d;
      logic [63:0]      mag;
      logic             upd;
      stp = 2'sb00;
      upd = 1'b0;
      case (r.mode)
         qdsm_pkg::MODE_PIN: begin
            cur = {r.pin_a, r.pin_b};
            stp = TRANSITION[{cur, st_pins}];
            st_count = st_count + {{30{stp[1]}}, stp};
            st_pins = cur;
         end
         qdsm_pkg::MODE_POS: begin
            st_snap = st_count;
            mag = magnitude(st_snap) * cfg_angle_gain;
            st_angle = lowpass(st_angle, sat32(st_snap[31], mag), cfg_angle_alpha);
         end
         qdsm_pkg::MODE_SPEED: begin
            if (r.elapsed_ticks != 32'd0 && r.elapsed_ticks >= cfg_min_ticks) begin
               d = st_snap - st_base;
               mag = (magnitude(d) * cfg_speed_gain) / {32'd0, r.elapsed_ticks};
               st_raw = sat32(d[31], mag);
               st_speed = lowpass(st_speed, st_raw, cfg_speed_alpha);
               st_base = st_snap;
               upd = 1'b1;
            end
         end
         default: ;
      endcase
      o.step           = stp;
      o.position_count = st_snap;
      o.direction      = st_snap[31];
      o.angle_filtered = st_angle;
      o.speed_raw      = st_raw;
      o.speed_filtered = st_speed;
      o.speed_updated  = upd;
      return o;
   endfunction

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         mismatches++;
         $display("%0t %s mismatch: expected %h actual %h", $time, name, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin
      qdsm_pkg::rsp_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (readout_q.size() == 0) begin
            mismatches++;
            $display("%0t unexpected transfer: expected none actual %h", $time, rsp_payload);
         end else begin
            exp_r = readout_q.pop_front();
            check_field("step", 32'(exp_r.step), 32'(rsp_payload.step));
            check_field("position_count", exp_r.position_count, rsp_payload.position_count);
            check_field("direction", 32'(exp_r.direction), 32'(rsp_payload.direction));
            check_field("angle_filtered", exp_r.angle_filtered, rsp_payload.angle_filtered);
            check_field("speed_raw", exp_r.speed_raw, rsp_payload.speed_raw);
            check_field("speed_filtered", exp_r.speed_filtered, rsp_payload.speed_filtered);
            check_field("speed_updated", 32'(exp_r.speed_updated),
                        32'(rsp_payload.speed_updated));
         end
      end
   end

   task automatic send_item(input qdsm_pkg::req_type r);
      while ($urandom_range(0, 99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      readout_q.push_back(meter_step(r));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (readout_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [qdsm_pkg::CSR_IDX_W-1:0] idx,
                            input logic [qdsm_pkg::CSR_W-1:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_write <= 1'b1;
      @(posedge clock);
      case (idx)
         qdsm_pkg::CSR_ANGLE_GAIN:  cfg_angle_gain  = data;
         qdsm_pkg::CSR_SPEED_GAIN:  cfg_speed_gain  = data;
         qdsm_pkg::CSR_ANGLE_ALPHA: cfg_angle_alpha = data[16:0];
         qdsm_pkg::CSR_SPEED_ALPHA: cfg_speed_alpha = data[16:0];
         qdsm_pkg::CSR_MIN_TICKS:   cfg_min_ticks   = data;
         default: ;
      endcase
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_all(input logic [31:0] ag, input logic [31:0] sg,
                            input logic [31:0] aa, input logic [31:0] sa,
                            input logic [31:0] mt);
      write_reg(qdsm_pkg::CSR_ANGLE_GAIN, ag);
      write_reg(qdsm_pkg::CSR_SPEED_GAIN, sg);
      write_reg(qdsm_pkg::CSR_ANGLE_ALPHA, aa);
      write_reg(qdsm_pkg::CSR_SPEED_ALPHA, sa);
      write_reg(qdsm_pkg::CSR_MIN_TICKS, mt);
   endtask

   // unused fields get random content
   function automatic qdsm_pkg::req_type mk(input logic [1:0] mode, input logic a,
                                            input logic b, input logic [31:0] ticks);
      qdsm_pkg::req_type r;
      r.mode          = mode;
      r.pin_a         = (mode == qdsm_pkg::MODE_PIN) ? a : 1'($urandom());
      r.pin_b         = (mode == qdsm_pkg::MODE_PIN) ? b : 1'($urandom());
      r.elapsed_ticks = (mode == qdsm_pkg::MODE_SPEED) ? ticks : $urandom();
      return r;
   endfunction

   function automatic logic [1:0] next_pins(input logic [1:0] s, input logic up);
      case (s)
         2'd0:    return up ? 2'd1 : 2'd2;
         2'd1:    return up ? 2'd3 : 2'd0;
         2'd3:    return up ? 2'd2 : 2'd1;
         default: return up ? 2'd0 : 2'd3;
      endcase
   endfunction

   function automatic qdsm_pkg::req_type make_item();
      int          s;
      int          m;
      logic [1:0]  p;
      logic [31:0] t;
      m = $urandom_range(0, 99);
      s = $urandom_range(0, 99);
      if (m < 55) begin
         if (s < 40)      p = next_pins(st_pins, 1'b1);
         else if (s < 75) p = next_pins(st_pins, 1'b0);
         else if (s < 85) p = st_pins;
         else             p = 2'($urandom());
         return mk(qdsm_pkg::MODE_PIN, p[1], p[0], 32'd0);
      end
      if (m < 75) return mk(qdsm_pkg::MODE_POS, 1'b0, 1'b0, 32'd0);
      if (m < 94) begin
         if (s < 15)      t = $urandom_range(0, 3);
         else if (s < 55) t = $urandom_range(0, 1000);
         else if (s < 75) t = cfg_min_ticks + $urandom_range(0, 4) - 32'd2;
         else             t = $urandom();
         return mk(qdsm_pkg::MODE_SPEED, 1'b0, 1'b0, t);
      end
      return mk(MODE_UNUSED, 1'b0, 1'b0, 32'd0);
   endfunction

   function automatic logic [31:0] pick_gain();
      if ($urandom_range(0, 99) < 20) return $urandom();
      return $urandom_range(1, 8 * 65536);
   endfunction

   function automatic logic [31:0] pick_alpha();
      if ($urandom_range(0, 99) < 15) return $urandom();
      return $urandom_range(0, 70000);
   endfunction

   task automatic test_directed_defaults();
      send_item(mk(qdsm_pkg::MODE_PIN, 1'b0, 1'b0, 32'd0));
      send_item(mk(qdsm_pkg::MODE_PIN, 1'b0, 1'b1, 32'd0));
      send_item(mk(qdsm_pkg::MODE_PIN, 1'b1, 1'b1, 32'd0));
      send_item(mk(qdsm_pkg::MODE_PIN, 1'b1, 1'b0, 32'd0));
      send_item(mk(qdsm_pkg::MODE_PIN, 1'b0, 1'b0, 32'd0));
      send_item(mk(qdsm_pkg::MODE_PIN, 1'b0, 1'b1, 32'd0));
      send_item(mk(qdsm_pkg::MODE_POS, 1'b0, 1'b0, 32'd0));
      send_item(mk(qdsm_pkg::MODE_SPEED, 1'b0, 1'b0, 32'd0));
      send_item(mk(qdsm_pkg::MODE_SPEED, 1'b0, 1'b0, 32'd99));
      send_item(mk(qdsm_pkg::MODE_SPEED, 1'b0, 1'b0, 32'd100));
      send_item(mk(qdsm_pkg::MODE_PIN, 1'b0, 1'b0, 32'd0));
      send_item(mk(qdsm_pkg::MODE_PIN, 1'b1, 1'b0, 32'd0));
      send_item(mk(qdsm_pkg::MODE_PIN, 1'b1, 1'b1, 32'd0));
      send_item(mk(qdsm_pkg::MODE_PIN, 1'b0, 1'b1, 32'd0));
      send_item(mk(qdsm_pkg::MODE_PIN, 1'b0, 1'b0, 32'd0));
      send_item(mk(qdsm_pkg::MODE_PIN, 1'b1, 1'b0, 32'd0));
      send_item(mk(qdsm_pkg::MODE_PIN, 1'b1, 1'b1, 32'd0));
      // double step: both phases change at once
      send_item(mk(qdsm_pkg::MODE_PIN, 1'b0, 1'b0, 32'd0));
      send_item(mk(qdsm_pkg::MODE_POS, 1'b0, 1'b0, 32'd0));
      send_item(mk(qdsm_pkg::MODE_SPEED, 1'b0, 1'b0, 32'hFFFF_FFFF));
      send_item(mk(MODE_UNUSED, 1'b1, 1'b1, 32'hFFFF_FFFF));
      send_item(mk(qdsm_pkg::MODE_POS, 1'b0, 1'b0, 32'd0));
      wait_idle();
   endtask

   task automatic test_register_extremes();
      write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0);
      send_item(mk(qdsm_pkg::MODE_PIN, 1'b1, 1'b0, 32'd0));
      send_item(mk(qdsm_pkg::MODE_POS, 1'b0, 1'b0, 32'd0));
      send_item(mk(qdsm_pkg::MODE_SPEED, 1'b0, 1'b0, 32'd1));
      send_item(mk(qdsm_pkg::MODE_SPEED, 1'b0, 1'b0, 32'd0));
      send_item(mk(qdsm_pkg::MODE_PIN, 1'b0, 1'b0, 32'd0));
      send_item(mk(qdsm_pkg::MODE_PIN, 1'b0, 1'b1, 32'd0));
      send_item(mk(qdsm_pkg::MODE_PIN, 1'b1, 1'b1, 32'd0));
      send_item(mk(qdsm_pkg::MODE_POS, 1'b0, 1'b0, 32'd0));
      send_item(mk(qdsm_pkg::MODE_SPEED, 1'b0, 1'b0, 32'd1));
      wait_idle();
      write_all(32'd0, 32'd0, 32'd65536, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(mk(qdsm_pkg::MODE_POS, 1'b0, 1'b0, 32'd0));
      send_item(mk(qdsm_pkg::MODE_SPEED, 1'b0, 1'b0, 32'hFFFF_FFFE));
      send_item(mk(qdsm_pkg::MODE_SPEED, 1'b0, 1'b0, 32'hFFFF_FFFF));
      wait_idle();
      write_all(32'd3 << 16, 32'd60 << 16, 32'h0001_0001, 32'd65536, 32'd1);
      send_item(mk(qdsm_pkg::MODE_PIN, 1'b1, 1'b0, 32'd0));
      send_item(mk(qdsm_pkg::MODE_PIN, 1'b0, 1'b0, 32'd0));
      send_item(mk(qdsm_pkg::MODE_POS, 1'b0, 1'b0, 32'd0));
      send_item(mk(qdsm_pkg::MODE_SPEED, 1'b0, 1'b0, 32'd1));
      send_item(mk(qdsm_pkg::MODE_SPEED, 1'b0, 1'b0, 32'd7));
      wait_idle();
   endtask

   task automatic test_random_traffic(input int snd_pct, input int rsp_pct, input int n);
      write_all(pick_gain(), pick_gain(), pick_alpha(), pick_alpha(),
                ($urandom_range(0, 99) < 10) ? $urandom() : $urandom_range(0, 300));
      snd_idle_pct = snd_pct;
      rsp_idle_pct = rsp_pct;
      repeat (n) send_item(make_item());
      wait_idle();
   endtask

   task automatic test_receiver_hold();
      snd_idle_pct = 0;
      rsp_idle_pct = 0;
      @(negedge clock);
      hold_left = 300;
      @(posedge clock);
      repeat (25) send_item(make_item());
      wait_idle();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      snd_idle_pct = 20;
      rsp_idle_pct = 57;
      test_directed_defaults();
      test_register_extremes();
      test_random_traffic(20, 57, 130);
      test_random_traffic(57, 20, 130);
      test_receiver_hold();
      test_random_traffic(0, 0, 130);
      write_all(32'd65536, 32'd65536, 32'd6554, 32'd6554, 32'd100);
      repeat (50) @(posedge clock);
      if (mismatches == 0 && readout_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ----- files.f -----
design/qdsm_pkg.sv
design/quadrature_decoder_speed_meter.sv
dv/tb_quadrature_decoder_speed_meter.sv
